>>> hw/rtl/glpd_pkg.sv
// Shared types and constants of the GIF LZW pixel decoder.
// Used by the top level, glpd_front and glpd_back; depends on nothing.
package glpd_pkg;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [3:0] RESET_MIN_CODE_SIZE = 4'd8;

   typedef enum logic [2:0] {
      ST_ACCEPTED  = 3'd0,
      ST_PIXEL     = 3'd1,
      ST_NEED_DATA = 3'd2,
      ST_FULL      = 3'd3,
      ST_DONE      = 3'd4,
      ST_ERROR     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      REG_MIN_CODE    = 3'd0,
      REG_WIDTH       = 3'd1,
      REG_HEIGHT      = 3'd2,
      REG_INTERLACED  = 3'd3,
      REG_TRANS_EN    = 3'd4,
      REG_TRANS_COLOR = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [3:0]  min_code_size;
      logic [15:0] pixels_per_row;
      logic [15:0] row_count;
      logic        interlaced;
      logic        transparency_enable;
      logic [7:0]  transparent_color;
   } cfg_type;

   typedef struct packed {
      logic       is_pop;
      logic [7:0] data_byte;
   } item_type;

   // Effective minimum code size, saturated to 1..8.
   function automatic logic [3:0] eff_min(input logic [3:0] m);
      logic [3:0] r;
      r = m;
      if (m < 4'd1) r = 4'd1;
      if (m > 4'd8) r = 4'd8;
      return r;
   endfunction

   function automatic logic [16:0] pass_start(input logic [1:0] p);
      logic [16:0] r;
      case (p)
         2'd0:    r = 17'd0;
         2'd1:    r = 17'd4;
         2'd2:    r = 17'd2;
         2'd3:    r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] pass_step(input logic [1:0] p);
      logic [16:0] r;
      case (p)
         2'd0:    r = 17'd8;
         2'd1:    r = 17'd8;
         2'd2:    r = 17'd4;
         2'd3:    r = 17'd2;
         default: r = 17'd8;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/gif_lzw_pixel_decoder.sv
// Top level of the GIF LZW pixel decoder: register port, input queue and
// decode engine. Depends on glpd_pkg, glpd_front and glpd_back (glpd_ram via glpd_back).
//
//   channel  direction  handshake                 payload
//   req      in         req_valid / req_ready     req_op, req_data_byte
//   rsp      out        rsp_valid / rsp_ready     status, index, opaque, x, y, last
//   csr      in         csr_psel/penable/pready   csr_paddr, csr_pwdata, csr_prdata
//
// Push: the beat passes the input queue, then the result register. A pop served
// from the string stack passes S_EMIT_RD and S_EMIT. A pop that reads codes adds
// S_DECODE, S_WALK, and S_WALK_DATA per prefix chain entry (registered reads).
// Reset is synchronous and clears control state; the tables need no clearing.
// A write of the minimum code size restarts the code table through restart_ff.
// The queue keeps taking beats while a result waits on rsp_ready, until both entries are full.
module gif_lzw_pixel_decoder #(
   parameter int MAX_CODE_BITS   = 12,
   parameter int STACK_DEPTH     = 4096,
   parameter int BIT_BUFFER_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_pixel_index,
   output logic        rsp_opaque,
   output logic [15:0] rsp_pixel_x,
   output logic [15:0] rsp_pixel_y,
   output logic        rsp_last_pixel,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import glpd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       restart_ff, restart_in;
   logic       wr;
   logic [2:0] idx;
   logic       q_valid;
   item_type   q_item;
   logic       q_pop;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = csr_paddr[4:2];

   always_comb begin
      cfg_in     = cfg_ff;
      restart_in = 1'b0;
      if (wr) begin
         case (idx)
            REG_MIN_CODE: begin
               cfg_in.min_code_size = csr_pwdata[3:0];
               restart_in = 1'b1;
            end
            REG_WIDTH:       cfg_in.pixels_per_row      = csr_pwdata[15:0];
            REG_HEIGHT:      cfg_in.row_count           = csr_pwdata[15:0];
            REG_INTERLACED:  cfg_in.interlaced          = csr_pwdata[0];
            REG_TRANS_EN:    cfg_in.transparency_enable = csr_pwdata[0];
            REG_TRANS_COLOR: cfg_in.transparent_color   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_MIN_CODE:    csr_prdata = {28'd0, cfg_ff.min_code_size};
         REG_WIDTH:       csr_prdata = {16'd0, cfg_ff.pixels_per_row};
         REG_HEIGHT:      csr_prdata = {16'd0, cfg_ff.row_count};
         REG_INTERLACED:  csr_prdata = {31'd0, cfg_ff.interlaced};
         REG_TRANS_EN:    csr_prdata = {31'd0, cfg_ff.transparency_enable};
         REG_TRANS_COLOR: csr_prdata = {24'd0, cfg_ff.transparent_color};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // The restart is delayed so that the engine sees the new code size.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_code_size       <= RESET_MIN_CODE_SIZE;
         cfg_ff.pixels_per_row      <= 16'd1;
         cfg_ff.row_count           <= 16'd1;
         cfg_ff.interlaced          <= 1'b0;
         cfg_ff.transparency_enable <= 1'b0;
         cfg_ff.transparent_color   <= 8'd0;
         restart_ff                 <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         restart_ff <= restart_in;
      end
   end

   glpd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   glpd_back #(
      .MAX_CODE_BITS   (MAX_CODE_BITS),
      .STACK_DEPTH     (STACK_DEPTH),
      .BIT_BUFFER_BITS (BIT_BUFFER_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .restart         (restart_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_opaque      (rsp_opaque),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_last_pixel  (rsp_last_pixel)
   );
endmodule

>>> hw/rtl/glpd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the code tables and the string stack.
module glpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hw/rtl/glpd_front.sv
// Input side: takes request beats, tags them as push or pop and holds
// them in a two-entry queue for the decode engine. Depends on glpd_pkg.
module glpd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [7:0]          req_data_byte,
   output logic                q_valid,
   output glpd_pkg::item_type  q_item,
   input  logic                q_pop
);
   import glpd_pkg::*;

   item_type   slot_ff [2];
   item_type   slot_in [2];
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   incoming;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[0];

   always_comb begin
      incoming.is_pop    = (req_op == OP_POP);
      incoming.data_byte = req_data_byte;
      slot_in  = slot_ff;
      count_in = count_ff;
      if (q_pop && q_valid) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_ff - 2'd1;
      end
      if (push) begin
         slot_in[count_in[0]] = incoming;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff <= slot_in;
   end
endmodule

>>> hw/rtl/glpd_back.sv
// Decode engine: bit buffer, LZW code tables, string stack and pixel
// position. Depends on glpd_pkg and glpd_ram.
module glpd_back #(
   parameter int MAX_CODE_BITS   = 12,
   parameter int STACK_DEPTH     = 4096,
   parameter int BIT_BUFFER_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  glpd_pkg::cfg_type  cfg,
   input  logic               restart,
   input  logic               q_valid,
   input  glpd_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_pixel_index,
   output logic               rsp_opaque,
   output logic [15:0]        rsp_pixel_x,
   output logic [15:0]        rsp_pixel_y,
   output logic               rsp_last_pixel
);
   import glpd_pkg::*;

   localparam int CB    = MAX_CODE_BITS;
   localparam int NC_W  = MAX_CODE_BITS + 1;
   localparam int SA_W  = $clog2(STACK_DEPTH);
   localparam int SC_W  = $clog2(STACK_DEPTH + 1);
   localparam int BB    = BIT_BUFFER_BITS;
   localparam int CNT_W = $clog2(BIT_BUFFER_BITS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_WALK, S_WALK_DATA, S_EMIT_RD, S_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [BB-1:0]    buf_ff, buf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SC_W-1:0]  stk_cnt_ff, stk_cnt_in;
   logic [NC_W-1:0]  next_ff, next_in;
   logic [3:0]       cw_ff, cw_in;
   logic [CB-1:0]    prev_ff, prev_in;
   logic [7:0]       first_ff, first_in;
   logic             await_ff, await_in;
   logic [15:0]      col_ff, col_in;
   logic [15:0]      row_ff, row_in;
   logic [1:0]       pass_ff, pass_in;
   logic             fin_ff, fin_in;
   logic             fail_ff, fail_in;
   logic [CB-1:0]    cur_ff, cur_in;
   logic [CB-1:0]    in_code_ff, in_code_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       status_ff, status_in;
   logic [7:0]       index_ff, index_in;
   logic             opaque_ff, opaque_in;
   logic [15:0]      x_ff, x_in;
   logic [15:0]      y_ff, y_in;
   logic             last_ff, last_in;

   logic             stk_we;
   logic [7:0]       stk_wdata;
   logic [7:0]       stk_rdata;
   logic             tbl_we;
   logic [CB-1:0]    prefix_rdata;
   logic [7:0]       suffix_rdata;

   logic [3:0]       emin;
   logic [NC_W-1:0]  clr_code;
   logic [NC_W-1:0]  restart_next;
   logic [3:0]       restart_cw;
   logic [CB-1:0]    code;
   logic [NC_W-1:0]  code_x;
   logic             stk_full;
   logic             out_free;

   glpd_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_cnt_ff[SA_W-1:0]),
      .wdata (stk_wdata),
      .raddr (SA_W'(stk_cnt_ff - SC_W'(1))),
      .rdata (stk_rdata)
   );

   glpd_ram #(.WIDTH(CB), .DEPTH(1 << MAX_CODE_BITS)) u_prefix (
      .clock (clock),
      .we    (tbl_we),
      .waddr (next_ff[CB-1:0]),
      .wdata (prev_ff),
      .raddr (cur_ff),
      .rdata (prefix_rdata)
   );

   glpd_ram #(.WIDTH(8), .DEPTH(1 << MAX_CODE_BITS)) u_suffix (
      .clock (clock),
      .we    (tbl_we),
      .waddr (next_ff[CB-1:0]),
      .wdata (cur_ff[7:0]),
      .raddr (cur_ff),
      .rdata (suffix_rdata)
   );

   assign emin         = eff_min(cfg.min_code_size);
   assign clr_code     = NC_W'(1) << emin;
   assign restart_next = clr_code + NC_W'(2);
   assign restart_cw   = emin + 4'd1;
   assign code         = buf_ff[CB-1:0] & CB'((NC_W'(1) << cw_ff) - NC_W'(1));
   assign code_x       = {1'b0, code};
   assign stk_full     = (stk_cnt_ff >= SC_W'(STACK_DEPTH));
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign q_pop        = (state_ff == S_IDLE) && out_free && q_valid;

   always_comb begin
      logic [CNT_W:0] fill;
      logic [16:0]    col1;
      logic [16:0]    r;
      logic [1:0]     p;
      logic           f;

      state_in     = state_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      stk_cnt_in   = stk_cnt_ff;
      next_in      = next_ff;
      cw_in        = cw_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      await_in     = await_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pass_in      = pass_ff;
      fin_in       = fin_ff;
      fail_in      = fail_ff;
      cur_in       = cur_ff;
      in_code_in   = in_code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      index_in     = index_ff;
      opaque_in    = opaque_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_in      = last_ff;
      stk_we       = 1'b0;
      stk_wdata    = 8'd0;
      tbl_we       = 1'b0;
      fill         = {1'b0, cnt_ff} + (CNT_W + 1)'(8);
      col1         = 17'd0;
      r            = 17'd0;
      p            = 2'd0;
      f            = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_ACCEPTED;
               index_in     = 8'd0;
               opaque_in    = 1'b0;
               x_in         = 16'd0;
               y_in         = 16'd0;
               last_in      = 1'b0;
               if (!q_item.is_pop) begin
                  if (fill > (CNT_W + 1)'(BB)) begin
                     status_in = ST_FULL;
                  end else begin
                     buf_in = buf_ff | (BB'(q_item.data_byte) << cnt_ff);
                     cnt_in = fill[CNT_W-1:0];
                  end
               end else if (fail_ff) begin
                  status_in = ST_ERROR;
               end else if (fin_ff) begin
                  status_in = ST_DONE;
               end else begin
                  rsp_valid_in = rsp_valid_ff && !rsp_ready;
                  state_in     = (stk_cnt_ff != SC_W'(0)) ? S_EMIT_RD : S_DECODE;
               end
            end
         end
         S_DECODE: begin
            if (cnt_ff < CNT_W'(cw_ff)) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_NEED_DATA;
               state_in     = S_IDLE;
            end else begin
               buf_in = buf_ff >> cw_ff;
               cnt_in = cnt_ff - CNT_W'(cw_ff);
               if (code_x == clr_code) begin
                  next_in  = restart_next;
                  cw_in    = restart_cw;
                  await_in = 1'b1;
               end else if (code_x == clr_code + NC_W'(1)) begin
                  fail_in      = 1'b1;
                  rsp_valid_in = 1'b1;
                  status_in    = ST_ERROR;
                  state_in     = S_IDLE;
               end else if (await_ff) begin
                  if (code_x > clr_code) begin
                     fail_in      = 1'b1;
                     rsp_valid_in = 1'b1;
                     status_in    = ST_ERROR;
                     state_in     = S_IDLE;
                  end else begin
                     await_in   = 1'b0;
                     prev_in    = code;
                     first_in   = code[7:0];
                     stk_we     = 1'b1;
                     stk_wdata  = code[7:0];
                     stk_cnt_in = stk_cnt_ff + SC_W'(1);
                     state_in   = S_EMIT_RD;
                  end
               end else if (code_x > next_ff) begin
                  fail_in      = 1'b1;
                  rsp_valid_in = 1'b1;
                  status_in    = ST_ERROR;
                  state_in     = S_IDLE;
               end else begin
                  in_code_in = code;
                  state_in   = S_WALK;
                  if (code_x == next_ff) begin
                     // Code not yet in the table: string of the previous
                     // code followed by its own first character.
                     stk_we     = 1'b1;
                     stk_wdata  = first_ff;
                     stk_cnt_in = stk_cnt_ff + SC_W'(1);
                     cur_in     = prev_ff;
                  end else begin
                     cur_in = code;
                  end
               end
            end
         end
         S_WALK: begin
            if ({1'b0, cur_ff} >= clr_code + NC_W'(2)) begin
               state_in = S_WALK_DATA;
            end else if (stk_full) begin
               fail_in      = 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = ST_ERROR;
               state_in     = S_IDLE;
            end else begin
               stk_we     = 1'b1;
               stk_wdata  = cur_ff[7:0];
               stk_cnt_in = stk_cnt_ff + SC_W'(1);
               first_in   = cur_ff[7:0];
               if (next_ff < (NC_W'(1) << CB)) begin
                  tbl_we  = 1'b1;
                  next_in = next_ff + NC_W'(1);
                  if (next_in >= (NC_W'(1) << cw_ff) && cw_ff < 4'(MAX_CODE_BITS)) begin
                     cw_in = cw_ff + 4'd1;
                  end
               end
               prev_in  = in_code_ff;
               state_in = S_EMIT_RD;
            end
         end
         S_WALK_DATA: begin
            if (stk_full) begin
               fail_in      = 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = ST_ERROR;
               state_in     = S_IDLE;
            end else begin
               stk_we     = 1'b1;
               stk_wdata  = suffix_rdata;
               stk_cnt_in = stk_cnt_ff + SC_W'(1);
               cur_in     = prefix_rdata;
               state_in   = S_WALK;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            stk_cnt_in   = stk_cnt_ff - SC_W'(1);
            rsp_valid_in = 1'b1;
            status_in    = ST_PIXEL;
            index_in     = stk_rdata;
            opaque_in    = !(cfg.transparency_enable && stk_rdata == cfg.transparent_color);
            x_in         = col_ff;
            y_in         = row_ff;
            col1         = {1'b0, col_ff} + 17'd1;
            f            = fin_ff;
            p            = pass_ff;
            r            = {1'b0, row_ff};
            if (col1 < {1'b0, cfg.pixels_per_row}) begin
               col_in = col1[15:0];
            end else begin
               col_in = 16'd0;
               if (!cfg.interlaced) begin
                  r = r + 17'd1;
                  if (r >= {1'b0, cfg.row_count}) f = 1'b1;
               end else begin
                  r = r + pass_step(pass_ff);
                  // Move on through the passes whose start row does not fit; finish after the last.
                  for (int k = 0; k < 4; k++) begin
                     if (!f && r >= {1'b0, cfg.row_count}) begin
                        if (p == 2'd3) begin
                           f = 1'b1;
                        end else begin
                           p = p + 2'd1;
                           r = pass_start(p);
                        end
                     end
                  end
               end
               row_in = r[15:0];
            end
            pass_in  = p;
            fin_in   = f;
            last_in  = f;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (restart) begin
         next_in  = restart_next;
         cw_in    = restart_cw;
         await_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         buf_ff       <= '0;
         cnt_ff       <= '0;
         stk_cnt_ff   <= '0;
         next_ff      <= (NC_W'(1) << RESET_MIN_CODE_SIZE) + NC_W'(2);
         cw_ff        <= RESET_MIN_CODE_SIZE + 4'd1;
         prev_ff      <= '0;
         first_ff     <= '0;
         await_ff     <= 1'b1;
         col_ff       <= '0;
         row_ff       <= '0;
         pass_ff      <= '0;
         fin_ff       <= 1'b0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         stk_cnt_ff   <= stk_cnt_in;
         next_ff      <= next_in;
         cw_ff        <= cw_in;
         prev_ff      <= prev_in;
         first_ff     <= first_in;
         await_ff     <= await_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pass_ff      <= pass_in;
         fin_ff       <= fin_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff     <= cur_in;
      in_code_ff <= in_code_in;
      status_ff  <= status_in;
      index_ff   <= index_in;
      opaque_ff  <= opaque_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      last_ff    <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_pixel_index = index_ff;
   assign rsp_opaque      = opaque_ff;
   assign rsp_pixel_x     = x_ff;
   assign rsp_pixel_y     = y_ff;
   assign rsp_last_pixel  = last_ff;
endmodule
